// ----- sv/gte_pkg.sv -----
// Shared constants, codes and types of the graph traversal engine.
// No dependencies; every other file but gte_ram uses it by scoped names.
package gte_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 256;
	localparam int WORK_DEPTH   = 1024;

	localparam int VERT_W  = 6;
	localparam int CMD_W   = 2;
	localparam int MODE_W  = 2;
	localparam int ST_W    = 2;
	localparam int VC_W    = 7;
	localparam int EDGE_W  = $clog2(MAX_EDGES);
	localparam int EUSED_W = $clog2(MAX_EDGES + 1);
	localparam int WS_AW   = $clog2(WORK_DEPTH);
	localparam int WS_PW   = $clog2(WORK_DEPTH + 1);
	localparam int FRAME_W = EDGE_W + 1;
	localparam int HT_W    = 2 * EDGE_W;

	localparam logic [FRAME_W-1:0] FRAME_NONE = {1'b1, {EDGE_W{1'b0}}};

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WALK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	localparam logic [MODE_W-1:0] MODE_BFS   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STACK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REC   = 2'd2;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_VERT = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd3;

	typedef logic [4:0] op_t;

	localparam op_t OP_NOP      = 5'd0;
	localparam op_t OP_LATCH    = 5'd1;
	localparam op_t OP_CLEAR    = 5'd2;
	localparam op_t OP_RES_BAD  = 5'd3;
	localparam op_t OP_RES_FULL = 5'd4;
	localparam op_t OP_ADD_RD   = 5'd5;
	localparam op_t OP_ADD_WR   = 5'd6;
	localparam op_t OP_INIT     = 5'd7;
	localparam op_t OP_RINIT    = 5'd8;
	localparam op_t OP_POP      = 5'd9;
	localparam op_t OP_VISIT    = 5'd10;
	localparam op_t OP_HT       = 5'd11;
	localparam op_t OP_EDGE     = 5'd12;
	localparam op_t OP_RTOP     = 5'd13;
	localparam op_t OP_RPOP     = 5'd14;
	localparam op_t OP_RF       = 5'd15;
	localparam op_t OP_RE       = 5'd16;
	localparam op_t OP_RPUSH    = 5'd17;
	localparam op_t OP_FIN      = 5'd18;
	localparam op_t OP_FIN_OVF  = 5'd19;

	typedef struct packed {
		op_t op;
	} ctrl_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [MODE_W-1:0] mode;
		logic              out_free;
		logic              add_bad;
		logic              add_full;
		logic              start_bad;
		logic              work_empty;
		logic              u_nonempty;
		logic              at_tail;
		logic              w_new;
		logic              ws_full;
		logic              rec_full;
		logic              frame_none;
	} stat_t;

endpackage

// ----- sv/gte_if.sv -----
// Request and result channel interfaces of the graph traversal engine.
// Depends on gte_pkg for field widths.
interface gte_req_if;
	logic                       valid;
	logic                       ready;
	logic [gte_pkg::CMD_W-1:0]  command;
	logic [gte_pkg::VERT_W-1:0] edge_from;
	logic [gte_pkg::VERT_W-1:0] edge_to;
	logic [gte_pkg::VERT_W-1:0] start_vertex;
	logic [gte_pkg::MODE_W-1:0] walk_mode;
	modport source (output valid, command, edge_from, edge_to, start_vertex, walk_mode,
		input ready);
	modport sink (input valid, command, edge_from, edge_to, start_vertex, walk_mode,
		output ready);
endinterface

interface gte_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [gte_pkg::VERT_W-1:0] vertex_out;
	logic                       last;
	logic [gte_pkg::ST_W-1:0]   status;
	modport source (output valid, vertex_out, last, status, input ready);
	modport sink (input valid, vertex_out, last, status, output ready);
endinterface

// ----- sv/gte_ram.sv -----
// Generic one-write one-read RAM with registered read data.
// No dependencies.
module gte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ----- sv/gte_dp.sv -----
// Datapath: edge, list, work and frame memories, marks, pointers, result register.
// Depends on gte_pkg and gte_ram; driven by op codes from gte_ctrl.
module gte_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [gte_pkg::VC_W-1:0]   cfg_wdata,
	input  logic [gte_pkg::CMD_W-1:0]  command,
	input  logic [gte_pkg::VERT_W-1:0] edge_from,
	input  logic [gte_pkg::VERT_W-1:0] edge_to,
	input  logic [gte_pkg::VERT_W-1:0] start_vertex,
	input  logic [gte_pkg::MODE_W-1:0] walk_mode,
	input  gte_pkg::ctrl_t             ctl,
	input  logic                       out_ready,
	output gte_pkg::stat_t             stat,
	output logic                       out_valid,
	output logic [gte_pkg::VERT_W-1:0] out_vertex,
	output logic                       out_last,
	output logic [gte_pkg::ST_W-1:0]   out_status
);
	localparam int VW = gte_pkg::VERT_W;
	localparam int EW = gte_pkg::EDGE_W;
	localparam int NV = gte_pkg::MAX_VERTICES;

	logic [gte_pkg::CMD_W-1:0]   cmd_q;
	logic [VW-1:0]               from_q, to_q, start_q, w_q, pend_q;
	logic [gte_pkg::MODE_W-1:0]  mode_q;
	logic [gte_pkg::VC_W-1:0]    vc_q, vc_sat;
	logic [gte_pkg::EUSED_W-1:0] edges_used_q;
	logic [NV-1:0]               nonempty_q, visited_q;
	logic [gte_pkg::WS_PW-1:0]   ptr_q, qh_q, ptr_m1;
	logic [EW-1:0]               e_q, tail_q, e_new;
	logic                        pend_v_q, out_v_q;
	logic                        is_bfs, is_stack;

	logic                        ht_we, ht_re, ed_re, tgt_we, lnk_we, ws_we, ws_re, fr_we, fr_re;
	logic [VW-1:0]               ht_waddr, ht_raddr;
	logic [gte_pkg::HT_W-1:0]    ht_wdata, ht_rdata;
	logic [EW-1:0]               ed_raddr, lnk_waddr, lnk_rdata;
	logic [VW-1:0]               tgt_rdata;
	logic [gte_pkg::WS_AW-1:0]   ws_waddr, ws_raddr;
	logic [VW-1:0]               ws_wdata, ws_rdata;
	logic [VW-1:0]               fr_waddr, fr_raddr;
	logic [gte_pkg::FRAME_W-1:0] fr_wdata, fr_rdata;

	logic                        mark_en, emit_en, fin_en, single_en;
	logic [VW-1:0]               mark_idx, emit_val;
	logic [gte_pkg::ST_W-1:0]    res_st;

	gte_ram #(.WIDTH(gte_pkg::HT_W), .DEPTH(NV)) u_ht (
		.clk, .we(ht_we), .waddr(ht_waddr), .wdata(ht_wdata),
		.re(ht_re), .raddr(ht_raddr), .rdata(ht_rdata));
	gte_ram #(.WIDTH(VW), .DEPTH(gte_pkg::MAX_EDGES)) u_tgt (
		.clk, .we(tgt_we), .waddr(e_new), .wdata(to_q),
		.re(ed_re), .raddr(ed_raddr), .rdata(tgt_rdata));
	gte_ram #(.WIDTH(EW), .DEPTH(gte_pkg::MAX_EDGES)) u_lnk (
		.clk, .we(lnk_we), .waddr(lnk_waddr), .wdata(e_new),
		.re(ed_re), .raddr(ed_raddr), .rdata(lnk_rdata));
	gte_ram #(.WIDTH(VW), .DEPTH(gte_pkg::WORK_DEPTH)) u_ws (
		.clk, .we(ws_we), .waddr(ws_waddr), .wdata(ws_wdata),
		.re(ws_re), .raddr(ws_raddr), .rdata(ws_rdata));
	gte_ram #(.WIDTH(gte_pkg::FRAME_W), .DEPTH(NV)) u_fr (
		.clk, .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
		.re(fr_re), .raddr(fr_raddr), .rdata(fr_rdata));

	assign vc_sat   = (vc_q > gte_pkg::VC_W'(NV)) ? gte_pkg::VC_W'(NV) : vc_q;
	assign is_stack = (mode_q == gte_pkg::MODE_STACK);
	assign is_bfs   = !(mode_q == gte_pkg::MODE_STACK || mode_q == gte_pkg::MODE_REC);
	assign ptr_m1   = ptr_q - gte_pkg::WS_PW'(1);
	assign e_new    = edges_used_q[EW-1:0];

	always_comb begin
		stat.cmd        = cmd_q;
		stat.mode       = mode_q;
		stat.out_free   = !out_v_q || out_ready;
		stat.add_bad    = ({1'b0, from_q} >= vc_sat) || ({1'b0, to_q} >= vc_sat);
		stat.add_full   = (edges_used_q >= gte_pkg::EUSED_W'(gte_pkg::MAX_EDGES));
		stat.start_bad  = ({1'b0, start_q} >= vc_sat);
		stat.work_empty = is_bfs ? (qh_q == ptr_q) : (ptr_q == '0);
		stat.u_nonempty = nonempty_q[ws_rdata];
		stat.at_tail    = (e_q == tail_q);
		stat.w_new      = !visited_q[tgt_rdata];
		stat.ws_full    = (ptr_q == gte_pkg::WS_PW'(gte_pkg::WORK_DEPTH));
		stat.rec_full   = (ptr_q >= gte_pkg::WS_PW'(NV));
		stat.frame_none = fr_rdata[EW];
	end

	always_comb begin
		ht_we = 1'b0; ht_waddr = from_q;
		ht_wdata = {(nonempty_q[from_q] ? ht_rdata[2*EW-1:EW] : e_new), e_new};
		ht_re = 1'b0; ht_raddr = from_q;
		ed_re = 1'b0; ed_raddr = lnk_rdata;
		tgt_we = 1'b0; lnk_we = 1'b0; lnk_waddr = ht_rdata[EW-1:0];
		ws_we = 1'b0; ws_waddr = ptr_q[gte_pkg::WS_AW-1:0]; ws_wdata = tgt_rdata;
		ws_re = 1'b0; ws_raddr = ptr_m1[gte_pkg::WS_AW-1:0];
		fr_we = 1'b0; fr_waddr = ptr_m1[VW-1:0];
		fr_wdata = (e_q == ht_rdata[EW-1:0]) ? gte_pkg::FRAME_NONE : {1'b0, lnk_rdata};
		fr_re = 1'b0; fr_raddr = ptr_m1[VW-1:0];
		mark_en = 1'b0; mark_idx = tgt_rdata;
		emit_en = 1'b0; emit_val = tgt_rdata;
		fin_en = 1'b0; single_en = 1'b0; res_st = gte_pkg::ST_OK;
		unique case (ctl.op)
			gte_pkg::OP_CLEAR: single_en = 1'b1;
			gte_pkg::OP_RES_BAD: begin
				single_en = 1'b1;
				res_st = gte_pkg::ST_BAD_VERT;
			end
			gte_pkg::OP_RES_FULL: begin
				single_en = 1'b1;
				res_st = gte_pkg::ST_FULL;
			end
			gte_pkg::OP_ADD_RD: ht_re = 1'b1;
			gte_pkg::OP_ADD_WR: begin
				ht_we = 1'b1;
				tgt_we = 1'b1;
				lnk_we = nonempty_q[from_q];
				single_en = 1'b1;
			end
			gte_pkg::OP_INIT: begin
				ws_we = 1'b1;
				ws_waddr = '0;
				ws_wdata = start_q;
				mark_idx = start_q;
				mark_en = !is_stack;
				emit_val = start_q;
				emit_en = (mode_q == gte_pkg::MODE_REC);
				ht_re = 1'b1;
				ht_raddr = start_q;
			end
			gte_pkg::OP_RINIT: begin
				fr_we = 1'b1;
				fr_waddr = '0;
				fr_wdata = nonempty_q[start_q] ? {1'b0, ht_rdata[2*EW-1:EW]}
					: gte_pkg::FRAME_NONE;
			end
			gte_pkg::OP_POP: begin
				ws_re = 1'b1;
				if (is_bfs)
					ws_raddr = qh_q[gte_pkg::WS_AW-1:0];
			end
			gte_pkg::OP_VISIT: begin
				emit_val = ws_rdata;
				mark_idx = ws_rdata;
				emit_en = is_bfs || !visited_q[ws_rdata];
				mark_en = !is_bfs;
				ht_re = 1'b1;
				ht_raddr = ws_rdata;
			end
			gte_pkg::OP_HT: begin
				ed_re = 1'b1;
				ed_raddr = ht_rdata[2*EW-1:EW];
			end
			gte_pkg::OP_EDGE: begin
				ws_we = !visited_q[tgt_rdata];
				mark_en = is_bfs && !visited_q[tgt_rdata];
				ed_re = (e_q != tail_q);
			end
			gte_pkg::OP_RTOP: begin
				fr_re = 1'b1;
				ws_re = 1'b1;
			end
			gte_pkg::OP_RPOP: ;
			gte_pkg::OP_RF: begin
				ht_re = 1'b1;
				ht_raddr = ws_rdata;
				ed_re = 1'b1;
				ed_raddr = fr_rdata[EW-1:0];
			end
			gte_pkg::OP_RE: begin
				fr_we = 1'b1;
				if (!visited_q[tgt_rdata]) begin
					mark_en = 1'b1;
					emit_en = 1'b1;
					ws_we = 1'b1;
					ht_re = 1'b1;
					ht_raddr = tgt_rdata;
				end
			end
			gte_pkg::OP_RPUSH: begin
				fr_we = 1'b1;
				fr_waddr = ptr_q[VW-1:0];
				fr_wdata = nonempty_q[w_q] ? {1'b0, ht_rdata[2*EW-1:EW]}
					: gte_pkg::FRAME_NONE;
			end
			gte_pkg::OP_FIN: fin_en = 1'b1;
			gte_pkg::OP_FIN_OVF: begin
				fin_en = 1'b1;
				res_st = gte_pkg::ST_OVERFLOW;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= gte_pkg::VC_W'(NV);
			edges_used_q <= '0;
			nonempty_q <= '0;
			visited_q <= '0;
			ptr_q <= '0;
			qh_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we)
				vc_q <= cfg_wdata;
			if (ctl.op == gte_pkg::OP_CLEAR) begin
				nonempty_q <= '0;
				edges_used_q <= '0;
			end
			if (ctl.op == gte_pkg::OP_ADD_WR) begin
				nonempty_q[from_q] <= 1'b1;
				edges_used_q <= edges_used_q + gte_pkg::EUSED_W'(1);
			end
			if (ctl.op == gte_pkg::OP_INIT)
				visited_q <= mark_en ? (NV'(1) << mark_idx) : '0;
			else if (mark_en)
				visited_q[mark_idx] <= 1'b1;
			unique case (ctl.op)
				gte_pkg::OP_INIT: begin
					ptr_q <= (mode_q == gte_pkg::MODE_REC) ? '0 : gte_pkg::WS_PW'(1);
					qh_q <= '0;
				end
				gte_pkg::OP_RINIT, gte_pkg::OP_RPUSH: ptr_q <= ptr_q + gte_pkg::WS_PW'(1);
				gte_pkg::OP_POP: begin
					if (is_bfs)
						qh_q <= qh_q + gte_pkg::WS_PW'(1);
					else
						ptr_q <= ptr_m1;
				end
				gte_pkg::OP_RPOP: ptr_q <= ptr_m1;
				gte_pkg::OP_EDGE: begin
					if (!visited_q[tgt_rdata])
						ptr_q <= ptr_q + gte_pkg::WS_PW'(1);
				end
				default: ;
			endcase
			if (single_en || fin_en || (emit_en && pend_v_q))
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
			if (fin_en)
				pend_v_q <= 1'b0;
			else if (emit_en)
				pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == gte_pkg::OP_LATCH) begin
			cmd_q <= command;
			from_q <= edge_from;
			to_q <= edge_to;
			start_q <= start_vertex;
			mode_q <= walk_mode;
		end
		if (ctl.op == gte_pkg::OP_HT) begin
			e_q <= ht_rdata[2*EW-1:EW];
			tail_q <= ht_rdata[EW-1:0];
		end
		if (ctl.op == gte_pkg::OP_EDGE)
			e_q <= lnk_rdata;
		if (ctl.op == gte_pkg::OP_RF)
			e_q <= fr_rdata[EW-1:0];
		if (ctl.op == gte_pkg::OP_RE)
			w_q <= tgt_rdata;
		if (emit_en)
			pend_q <= emit_val;
		if (single_en) begin
			out_vertex <= '0;
			out_last <= 1'b1;
			out_status <= res_st;
		end else if (fin_en) begin
			out_vertex <= pend_q;
			out_last <= 1'b1;
			out_status <= res_st;
		end else if (emit_en && pend_v_q) begin
			out_vertex <= pend_q;
			out_last <= 1'b0;
			out_status <= gte_pkg::ST_OK;
		end
	end

	assign out_valid = out_v_q;
endmodule

// ----- sv/gte_ctrl.sv -----
// Controller: sequences edge adds, clears and the three walk modes.
// Depends on gte_pkg; issues op codes to gte_dp and reads its status.
module gte_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  gte_pkg::stat_t stat,
	output gte_pkg::ctrl_t ctl
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_ADD   = 4'd2;
	localparam logic [3:0] S_RINIT = 4'd3;
	localparam logic [3:0] S_POP   = 4'd4;
	localparam logic [3:0] S_VISIT = 4'd5;
	localparam logic [3:0] S_HT    = 4'd6;
	localparam logic [3:0] S_EDGE  = 4'd7;
	localparam logic [3:0] S_RTOP  = 4'd8;
	localparam logic [3:0] S_RF    = 4'd9;
	localparam logic [3:0] S_RE    = 4'd10;
	localparam logic [3:0] S_RPUSH = 4'd11;

	logic [3:0] state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl.op = gte_pkg::OP_NOP;
		if (state_q == S_IDLE) begin
			if (req_valid) begin
				ctl.op = gte_pkg::OP_LATCH;
				state_d = S_DEC;
			end
		end else if (stat.out_free) begin
			unique case (state_q)
				S_DEC: begin
					state_d = S_IDLE;
					unique case (stat.cmd)
						gte_pkg::CMD_ADD: begin
							if (stat.add_bad)
								ctl.op = gte_pkg::OP_RES_BAD;
							else if (stat.add_full)
								ctl.op = gte_pkg::OP_RES_FULL;
							else begin
								ctl.op = gte_pkg::OP_ADD_RD;
								state_d = S_ADD;
							end
						end
						gte_pkg::CMD_WALK: begin
							if (stat.start_bad)
								ctl.op = gte_pkg::OP_RES_BAD;
							else begin
								ctl.op = gte_pkg::OP_INIT;
								state_d = (stat.mode == gte_pkg::MODE_REC) ? S_RINIT : S_POP;
							end
						end
						gte_pkg::CMD_CLEAR: ctl.op = gte_pkg::OP_CLEAR;
						gte_pkg::CMD_NOP: ctl.op = gte_pkg::OP_NOP;
						default: ;
					endcase
				end
				S_ADD: begin
					ctl.op = gte_pkg::OP_ADD_WR;
					state_d = S_IDLE;
				end
				S_RINIT: begin
					ctl.op = gte_pkg::OP_RINIT;
					state_d = S_RTOP;
				end
				S_POP: begin
					if (stat.work_empty) begin
						ctl.op = gte_pkg::OP_FIN;
						state_d = S_IDLE;
					end else begin
						ctl.op = gte_pkg::OP_POP;
						state_d = S_VISIT;
					end
				end
				S_VISIT: begin
					ctl.op = gte_pkg::OP_VISIT;
					state_d = stat.u_nonempty ? S_HT : S_POP;
				end
				S_HT: begin
					ctl.op = gte_pkg::OP_HT;
					state_d = S_EDGE;
				end
				S_EDGE: begin
					if (stat.w_new && stat.ws_full) begin
						ctl.op = gte_pkg::OP_FIN_OVF;
						state_d = S_IDLE;
					end else begin
						ctl.op = gte_pkg::OP_EDGE;
						state_d = stat.at_tail ? S_POP : S_EDGE;
					end
				end
				S_RTOP: begin
					if (stat.work_empty) begin
						ctl.op = gte_pkg::OP_FIN;
						state_d = S_IDLE;
					end else begin
						ctl.op = gte_pkg::OP_RTOP;
						state_d = S_RF;
					end
				end
				S_RF: begin
					if (stat.frame_none) begin
						ctl.op = gte_pkg::OP_RPOP;
						state_d = S_RTOP;
					end else begin
						ctl.op = gte_pkg::OP_RF;
						state_d = S_RE;
					end
				end
				S_RE: begin
					if (stat.w_new && stat.rec_full) begin
						ctl.op = gte_pkg::OP_FIN_OVF;
						state_d = S_IDLE;
					end else begin
						ctl.op = gte_pkg::OP_RE;
						state_d = stat.w_new ? S_RPUSH : S_RTOP;
					end
				end
				S_RPUSH: begin
					ctl.op = gte_pkg::OP_RPUSH;
					state_d = S_RTOP;
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule

// ----- sv/graph_traversal_engine.sv -----
// Top level of the graph traversal engine: controller, datapath, channel wiring.
// Depends on gte_pkg, gte_if, gte_ctrl and gte_dp.
//
// One request transaction at a time. A clear, a rejected add or walk, a stored add and the
// no-operation command each end before the next request is taken; all but the no-operation
// command give one result. A breadth-first or stack depth-first walk pops each vertex, reads
// its list head if the list is non-empty and scans each list entry; a recursive depth-first
// walk scans list entries through a frame per vertex visited. In stack mode a vertex can be
// pushed several times. Every memory step goes through a registered-read RAM.
// Results leave through one output register; the walk pauses while it is held.
// Stored lists start out empty; no clearing pass runs after reset.
module graph_traversal_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [gte_pkg::VC_W-1:0] cfg_wdata,
	gte_req_if.sink                  req,
	gte_rsp_if.source                rsp
);
	gte_pkg::ctrl_t ctl;
	gte_pkg::stat_t stat;

	gte_ctrl u_ctrl (
		.clk, .arst_n, .req_valid(req.valid), .req_ready(req.ready), .stat, .ctl);

	gte_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.command(req.command), .edge_from(req.edge_from), .edge_to(req.edge_to),
		.start_vertex(req.start_vertex), .walk_mode(req.walk_mode),
		.ctl, .out_ready(rsp.ready), .stat,
		.out_valid(rsp.valid), .out_vertex(rsp.vertex_out), .out_last(rsp.last),
		.out_status(rsp.status));
endmodule

// ----- sv/gte_chk.sv -----
// Port-level checker for graph_traversal_engine, attached by bind.
// Depends on gte_pkg for status codes.
module gte_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [gte_pkg::VERT_W-1:0] rsp_vertex_out,
	input logic                       rsp_last,
	input logic [gte_pkg::ST_W-1:0]   rsp_status
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex_out)
			&& $stable(rsp_last) && $stable(rsp_status))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == gte_pkg::ST_BAD_VERT || rsp_status == gte_pkg::ST_FULL)
			|-> rsp_last && rsp_vertex_out == '0)
		else $error("error result not a lone final result");

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == gte_pkg::ST_OVERFLOW |-> rsp_last)
		else $error("overflow status on non-final result");
endmodule

bind graph_traversal_engine gte_chk u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_vertex_out(rsp.vertex_out),
	.rsp_last(rsp.last), .rsp_status(rsp.status));
